### rtl/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// Shared widths and types for the segment intersection pipeline.
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int COORD_BITS = 16;
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int CW = PW + 1;
    localparam int NW = CW + DW;
    localparam int RW = NW + 2;
    localparam int QW = COORD_BITS + 1;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic   hit;
        logic   neg_x;
        logic   neg_y;
        coord_t p0x;
        coord_t p0y;
    } sit_tag_t;

endpackage

### rtl/sit_front.sv
// ----------------------------------------------------------------------------
// sit_front
// Differences, cross products, the unit-range test and the dividend and
// divisor magnitudes, in five register stages.
// ----------------------------------------------------------------------------
module sit_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_fire,
    input  sit_pkg::coord_t             a_start_x,
    input  sit_pkg::coord_t             a_start_y,
    input  sit_pkg::coord_t             a_end_x,
    input  sit_pkg::coord_t             a_end_y,
    input  sit_pkg::coord_t             b_start_x,
    input  sit_pkg::coord_t             b_start_y,
    input  sit_pkg::coord_t             b_end_x,
    input  sit_pkg::coord_t             b_end_y,
    output logic                        fr_valid,
    output sit_pkg::sit_tag_t           fr_tag,
    output logic [sit_pkg::RW-1:0]      fr_num_x,
    output logic [sit_pkg::RW-1:0]      fr_num_y,
    output logic [sit_pkg::RW-1:0]      fr_div
);
    import sit_pkg::*;

    logic [4:0] v_reg;

    logic signed [DW-1:0] s1x_reg, s1y_reg, s2x_reg, s2y_reg, dx_reg, dy_reg;
    coord_t               p0x1_reg, p0y1_reg;

    logic signed [PW-1:0] mda_reg, mdb_reg, msa_reg, msb_reg, mta_reg, mtb_reg;
    logic signed [DW-1:0] s1x2_reg, s1y2_reg;
    coord_t               p0x2_reg, p0y2_reg;

    logic signed [CW-1:0] den_reg, sn_reg, tn_reg;
    logic signed [DW-1:0] s1x3_reg, s1y3_reg;
    coord_t               p0x3_reg, p0y3_reg;

    logic                 hit4_reg;
    logic signed [NW-1:0] px_reg, py_reg;
    logic signed [CW-1:0] den4_reg;
    coord_t               p0x4_reg, p0y4_reg;

    sit_tag_t             tag5_reg;
    logic [RW-1:0]        nx5_reg, ny5_reg, d5_reg;

    logic                 sn_ok, tn_ok, hit_next;
    logic [NW-1:0]        mag_x, mag_y;
    logic [CW-1:0]        mag_d;

    always_comb
    begin
        if (den_reg > 0)
        begin
            sn_ok = (sn_reg >= 0) && (sn_reg <= den_reg);
            tn_ok = (tn_reg >= 0) && (tn_reg <= den_reg);
        end
        else
        begin
            sn_ok = (sn_reg <= 0) && (sn_reg >= den_reg);
            tn_ok = (tn_reg <= 0) && (tn_reg >= den_reg);
        end
        hit_next = (den_reg != 0) && sn_ok && tn_ok;
        mag_x = px_reg[NW-1] ? NW'(-px_reg) : NW'(px_reg);
        mag_y = py_reg[NW-1] ? NW'(-py_reg) : NW'(py_reg);
        mag_d = den4_reg[CW-1] ? CW'(-den4_reg) : CW'(den4_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[3:0], in_fire};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1x_reg  <= DW'(a_end_x) - DW'(a_start_x);
            s1y_reg  <= DW'(a_end_y) - DW'(a_start_y);
            s2x_reg  <= DW'(b_end_x) - DW'(b_start_x);
            s2y_reg  <= DW'(b_end_y) - DW'(b_start_y);
            dx_reg   <= DW'(a_start_x) - DW'(b_start_x);
            dy_reg   <= DW'(a_start_y) - DW'(b_start_y);
            p0x1_reg <= a_start_x;
            p0y1_reg <= a_start_y;

            mda_reg  <= s1x_reg * s2y_reg;
            mdb_reg  <= s2x_reg * s1y_reg;
            msa_reg  <= s1x_reg * dy_reg;
            msb_reg  <= s1y_reg * dx_reg;
            mta_reg  <= s2x_reg * dy_reg;
            mtb_reg  <= s2y_reg * dx_reg;
            s1x2_reg <= s1x_reg;
            s1y2_reg <= s1y_reg;
            p0x2_reg <= p0x1_reg;
            p0y2_reg <= p0y1_reg;

            den_reg  <= CW'(mda_reg) - CW'(mdb_reg);
            sn_reg   <= CW'(msa_reg) - CW'(msb_reg);
            tn_reg   <= CW'(mta_reg) - CW'(mtb_reg);
            s1x3_reg <= s1x2_reg;
            s1y3_reg <= s1y2_reg;
            p0x3_reg <= p0x2_reg;
            p0y3_reg <= p0y2_reg;

            hit4_reg <= hit_next;
            px_reg   <= tn_reg * s1x3_reg;
            py_reg   <= tn_reg * s1y3_reg;
            den4_reg <= den_reg;
            p0x4_reg <= p0x3_reg;
            p0y4_reg <= p0y3_reg;

            tag5_reg.hit   <= hit4_reg;
            tag5_reg.neg_x <= px_reg[NW-1] ^ den4_reg[CW-1];
            tag5_reg.neg_y <= py_reg[NW-1] ^ den4_reg[CW-1];
            tag5_reg.p0x   <= p0x4_reg;
            tag5_reg.p0y   <= p0y4_reg;
            nx5_reg <= RW'({mag_x, 1'b0}) + RW'(mag_d);
            ny5_reg <= RW'({mag_y, 1'b0}) + RW'(mag_d);
            d5_reg  <= RW'({mag_d, 1'b0});
        end
    end

    assign fr_valid = v_reg[4];
    assign fr_tag   = tag5_reg;
    assign fr_num_x = nx5_reg;
    assign fr_num_y = ny5_reg;
    assign fr_div   = d5_reg;

endmodule

### rtl/sit_div.sv
// ----------------------------------------------------------------------------
// sit_div
// Two-lane restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module sit_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        fr_valid,
    input  sit_pkg::sit_tag_t           fr_tag,
    input  logic [sit_pkg::RW-1:0]      fr_num_x,
    input  logic [sit_pkg::RW-1:0]      fr_num_y,
    input  logic [sit_pkg::RW-1:0]      fr_div,
    output logic                        dv_valid,
    output sit_pkg::sit_tag_t           dv_tag,
    output logic [sit_pkg::QW-1:0]      dv_quo_x,
    output logic [sit_pkg::QW-1:0]      dv_quo_y
);
    import sit_pkg::*;

    logic          v_reg   [1:QW];
    sit_tag_t      tag_reg [1:QW];
    logic [RW-1:0] rx_reg  [1:QW];
    logic [RW-1:0] ry_reg  [1:QW];
    logic [RW-1:0] d_reg   [1:QW];
    logic [QW-1:0] qx_reg  [1:QW];
    logic [QW-1:0] qy_reg  [1:QW];

    logic          v_in    [0:QW-1];
    sit_tag_t      tag_in  [0:QW-1];
    logic [RW-1:0] rx_in   [0:QW-1];
    logic [RW-1:0] ry_in   [0:QW-1];
    logic [RW-1:0] d_in    [0:QW-1];
    logic [QW-1:0] qx_in   [0:QW-1];
    logic [QW-1:0] qy_in   [0:QW-1];
    logic [RW-1:0] sub     [0:QW-1];
    logic          take_x  [0:QW-1];
    logic          take_y  [0:QW-1];

    always_comb
    begin
        v_in[0]   = fr_valid;
        tag_in[0] = fr_tag;
        rx_in[0]  = fr_num_x;
        ry_in[0]  = fr_num_y;
        d_in[0]   = fr_div;
        qx_in[0]  = '0;
        qy_in[0]  = '0;
        for (int k = 1; k < QW; k++)
        begin
            v_in[k]   = v_reg[k];
            tag_in[k] = tag_reg[k];
            rx_in[k]  = rx_reg[k];
            ry_in[k]  = ry_reg[k];
            d_in[k]   = d_reg[k];
            qx_in[k]  = qx_reg[k];
            qy_in[k]  = qy_reg[k];
        end
        for (int k = 0; k < QW; k++)
        begin
            sub[k]    = d_in[k] << (QW - 1 - k);
            take_x[k] = rx_in[k] >= sub[k];
            take_y[k] = ry_in[k] >= sub[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QW; k++)
            begin
                v_reg[k+1] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < QW; k++)
            begin
                v_reg[k+1] <= v_in[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QW; k++)
            begin
                tag_reg[k+1] <= tag_in[k];
                d_reg[k+1]   <= d_in[k];
                rx_reg[k+1]  <= take_x[k] ? rx_in[k] - sub[k] : rx_in[k];
                ry_reg[k+1]  <= take_y[k] ? ry_in[k] - sub[k] : ry_in[k];
                qx_reg[k+1]  <= qx_in[k] | (QW'(take_x[k]) << (QW - 1 - k));
                qy_reg[k+1]  <= qy_in[k] | (QW'(take_y[k]) << (QW - 1 - k));
            end
        end
    end

    assign dv_valid = v_reg[QW];
    assign dv_tag   = tag_reg[QW];
    assign dv_quo_x = qx_reg[QW];
    assign dv_quo_y = qy_reg[QW];

endmodule

### rtl/segment_intersection_test.sv
// ----------------------------------------------------------------------------
// segment_intersection_test
// Exact 2D segment intersection test with a rounded crossing point.
//
//   channel | valid     | stall     | payload
//   in      | in_valid  | in_stall  | a_start_x .. b_end_y
//   out     | out_valid | out_stall | hit, cross_x, cross_y
//
// One request is taken every cycle unless a valid output is stalled; the path runs
// through five front stages, one stage per quotient bit of the divider (17), and the output register.
// Reset clears all valid bits; no clearing pass is needed.
// A stall on a valid output freezes the whole pipeline in place.
// ----------------------------------------------------------------------------
module segment_intersection_test (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  sit_pkg::coord_t a_start_x,
    input  sit_pkg::coord_t a_start_y,
    input  sit_pkg::coord_t a_end_x,
    input  sit_pkg::coord_t a_end_y,
    input  sit_pkg::coord_t b_start_x,
    input  sit_pkg::coord_t b_start_y,
    input  sit_pkg::coord_t b_end_x,
    input  sit_pkg::coord_t b_end_y,
    output logic            out_valid,
    input  logic            out_stall,
    output logic            hit,
    output sit_pkg::coord_t cross_x,
    output sit_pkg::coord_t cross_y
);
    import sit_pkg::*;

    logic          en;
    logic          fr_valid, dv_valid;
    sit_tag_t      fr_tag, dv_tag;
    logic [RW-1:0] fr_num_x, fr_num_y, fr_div;
    logic [QW-1:0] dv_quo_x, dv_quo_y;
    logic          ov_reg, hit_reg;
    coord_t        cx_reg, cy_reg;
    coord_t        off_x, off_y;

    assign en       = !(ov_reg && out_stall);
    assign in_stall = !en;

    sit_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_fire   (in_valid),
        .a_start_x (a_start_x),
        .a_start_y (a_start_y),
        .a_end_x   (a_end_x),
        .a_end_y   (a_end_y),
        .b_start_x (b_start_x),
        .b_start_y (b_start_y),
        .b_end_x   (b_end_x),
        .b_end_y   (b_end_y),
        .fr_valid  (fr_valid),
        .fr_tag    (fr_tag),
        .fr_num_x  (fr_num_x),
        .fr_num_y  (fr_num_y),
        .fr_div    (fr_div)
    );

    sit_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .fr_valid (fr_valid),
        .fr_tag   (fr_tag),
        .fr_num_x (fr_num_x),
        .fr_num_y (fr_num_y),
        .fr_div   (fr_div),
        .dv_valid (dv_valid),
        .dv_tag   (dv_tag),
        .dv_quo_x (dv_quo_x),
        .dv_quo_y (dv_quo_y)
    );

    always_comb
    begin
        off_x = dv_tag.neg_x ? COORD_BITS'(~dv_quo_x + 1'b1) : COORD_BITS'(dv_quo_x);
        off_y = dv_tag.neg_y ? COORD_BITS'(~dv_quo_y + 1'b1) : COORD_BITS'(dv_quo_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            ov_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= dv_tag.hit;
            cx_reg  <= dv_tag.hit ? coord_t'(dv_tag.p0x + off_x) : '0;
            cy_reg  <= dv_tag.hit ? coord_t'(dv_tag.p0y + off_y) : '0;
        end
    end

    assign out_valid = ov_reg;
    assign hit       = hit_reg;
    assign cross_x   = cx_reg;
    assign cross_y   = cy_reg;

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> cross_x == 0 && cross_y == 0)
        else $error("miss with nonzero crossing point");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while output is blocked");

    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with an empty output");

    a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(dv_valid) && $stable(fr_valid))
        else $error("pipeline moved during a stall");

endmodule

### tb/sv/segment_intersection_test_tb.sv
// ----------------------------------------------------------------------------
// segment_intersection_test_tb
// Drives segment pairs into the intersection block with random gaps and output
// stalls, predicts hit and crossing point exactly, and compares every result.
// ----------------------------------------------------------------------------
module segment_intersection_test_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sit_pkg::*;

    localparam int LATENCY = 23;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic   hit;
        coord_t cx;
        coord_t cy;
    } crossing_t;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_stall;
    coord_t a_start_x, a_start_y, a_end_x, a_end_y;
    coord_t b_start_x, b_start_y, b_end_x, b_end_y;
    logic   out_valid;
    logic   out_stall;
    logic   hit;
    coord_t cross_x, cross_y;

    crossing_t expected_crossings[$];
    int        mismatch_count;
    int        cycle_count;
    int        burst_left;
    bit        stall_free;

    segment_intersection_test u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .a_start_x (a_start_x),
        .a_start_y (a_start_y),
        .a_end_x   (a_end_x),
        .a_end_y   (a_end_y),
        .b_start_x (b_start_x),
        .b_start_y (b_start_y),
        .b_end_x   (b_end_x),
        .b_end_y   (b_end_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hit       (hit),
        .cross_x   (cross_x),
        .cross_y   (cross_y)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("[segment_intersection_test] ERROR");
                $finish;
            end
        end
    end

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint rounded_quotient(longint num, longint den);
        longint unsigned n;
        longint unsigned d;
        longint unsigned q;
        n = magnitude(num);
        d = magnitude(den);
        q = (2 * n + d) / (2 * d);
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic bit within_unit(longint num, longint den);
        if (den > 0)
            return num >= 0 && num <= den;
        return num <= 0 && num >= den;
    endfunction

    function automatic crossing_t predict_crossing(coord_t p0x, coord_t p0y, coord_t p1x,
                                                   coord_t p1y, coord_t p2x, coord_t p2y,
                                                   coord_t p3x, coord_t p3y);
        crossing_t r;
        longint s1x, s1y, s2x, s2y, dx, dy, den, sn, tn;
        s1x = longint'(p1x) - longint'(p0x);
        s1y = longint'(p1y) - longint'(p0y);
        s2x = longint'(p3x) - longint'(p2x);
        s2y = longint'(p3y) - longint'(p2y);
        dx  = longint'(p0x) - longint'(p2x);
        dy  = longint'(p0y) - longint'(p2y);
        den = s1x * s2y - s2x * s1y;
        sn  = s1x * dy - s1y * dx;
        tn  = s2x * dy - s2y * dx;
        r = '0;
        if (den != 0 && within_unit(sn, den) && within_unit(tn, den))
        begin
            r.hit = 1'b1;
            r.cx  = coord_t'(longint'(p0x) + rounded_quotient(tn * s1x, den));
            r.cy  = coord_t'(longint'(p0y) + rounded_quotient(tn * s1y, den));
        end
        return r;
    endfunction

    // Sender works in bursts; a gap is inserted only before the first request of a burst.
    task automatic send_request(coord_t p0x, coord_t p0y, coord_t p1x, coord_t p1y,
                                coord_t p2x, coord_t p2y, coord_t p3x, coord_t p3y);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_valid  <= 1'b1;
        a_start_x <= p0x;
        a_start_y <= p0y;
        a_end_x   <= p1x;
        a_end_y   <= p1y;
        b_start_x <= p2x;
        b_start_y <= p2y;
        b_end_x   <= p3x;
        b_end_y   <= p3y;
        do
            @(posedge clk);
        while (in_stall);
        expected_crossings.push_back(predict_crossing(p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y));
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        crossing_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_crossings.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result hit=%0b x=%0d y=%0d", hit, cross_x, cross_y);
            end
            else
            begin
                want = expected_crossings.pop_front();
                if (hit !== want.hit || cross_x !== want.cx || cross_y !== want.cy)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
                                 want.hit, want.cx, want.cy, hit, cross_x, cross_y);
                end
            end
        end
    end

    // Output stall pattern: alternating free and noisy stretches.
    initial
    begin
        int span;
        out_stall  = 1'b0;
        stall_free = 1'b1;
        forever
        begin
            span = $urandom_range(5, 60);
            stall_free = ~stall_free;
            repeat (span)
            begin
                @(negedge clk);
                out_stall <= stall_free ? 1'b0 : ($urandom_range(0, 2) == 0);
            end
        end
    end

    function automatic coord_t random_coord();
        case ($urandom_range(0, 5))
            0: return coord_t'($urandom_range(0, 3) == 0 ? 16'h8000 : 16'h7fff);
            1: return coord_t'($urandom_range(0, 127) - 64);
            default: return coord_t'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        coord_t mx, mn;
        mx = 16'sh7fff;
        mn = 16'sh8000;
        send_request(0, 0, 640, 640, 0, 640, 640, 0);
        send_request(0, 0, 640, 0, 0, 64, 640, 64);
        send_request(0, 0, 640, 0, 128, 0, 512, 0);
        send_request(0, 0, 640, 640, 640, 640, 1280, 0);
        send_request(0, 0, 640, 0, 640, -64, 640, 64);
        send_request(0, 0, 640, 0, 0, -64, 0, 64);
        send_request(100, 100, 100, 100, 0, 0, 200, 200);
        send_request(0, 0, 640, 640, 0, 0, 640, 640);
        send_request(0, 0, 640, 0, 700, -64, 700, 64);
        send_request(mn, mn, mx, mx, mn, mx, mx, mn);
        send_request(mx, mx, mn, mn, mx, mn, mn, mx);
        send_request(mn, 0, mx, 0, 0, mn, 0, mx);
        send_request(mn, mn, mx, mn, mn, mn, mn, mx);
        send_request(0, 0, 3, 1, 1, 0, 1, 1);
        send_request(0, 0, -3, -1, -1, 0, -1, -1);
        send_request(0, 0, 3, 2, 1, 5, 1, -5);
        send_request(-1, -1, -1, -1, -1, -1, -1, -1);
        send_request(mx, mx, mx, mx, mx, mx, mx, mx);
    endtask

    task automatic test_random_crossings();
        coord_t cx, cy, p0x, p0y, p2x, p2y;
        int span;
        repeat (300)
        begin
            span = ($urandom_range(0, 7) == 0) ? 16000 : 2000;
            cx  = coord_t'($urandom_range(0, 2 * span) - span);
            cy  = coord_t'($urandom_range(0, 2 * span) - span);
            p0x = coord_t'(cx - ($urandom_range(0, 2 * span) - span));
            p0y = coord_t'(cy - ($urandom_range(0, 2 * span) - span));
            p2x = coord_t'(cx - ($urandom_range(0, 2 * span) - span));
            p2y = coord_t'(cy - ($urandom_range(0, 2 * span) - span));
            send_request(p0x, p0y, coord_t'(2 * cx - p0x), coord_t'(2 * cy - p0y),
                         p2x, p2y, coord_t'(2 * cx - p2x), coord_t'(2 * cy - p2y));
        end
    endtask

    task automatic test_random_noise();
        repeat (150)
            send_request(random_coord(), random_coord(), random_coord(), random_coord(),
                         random_coord(), random_coord(), random_coord(), random_coord());
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        {a_start_x, a_start_y, a_end_x, a_end_y} = '0;
        {b_start_x, b_start_y, b_end_x, b_end_y} = '0;
        mismatch_count = 0;
        burst_left = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random_crossings();
        test_random_noise();
        in_valid <= 1'b0;
        wait (expected_crossings.size() == 0);
        repeat (2 * LATENCY) @(posedge clk);
        if (mismatch_count == 0 && expected_crossings.size() == 0)
            $display("[segment_intersection_test] OK");
        else
            $display("[segment_intersection_test] ERROR");
        $finish;
    end

endmodule
